@@ rtl/assert_macros.svh @@
// Assertion shorthands used by double_hash_table.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds whenever ante holds at a clock edge out of reset.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Check that expr never holds at a clock edge out of reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("forbidden condition seen");

`endif

@@ rtl/dht_pkg.sv @@
`timescale 1ns / 1ps

package dht_pkg;

    // Default slot count (prime)
    localparam int TABLE_SIZE_DEF = 29;

    // Payload widths
    localparam int KEY_W    = 16;
    localparam int TAG_W    = 32;
    localparam int SLOT_W   = 5;
    localparam int STATUS_W = 2;

    // Request actions
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_FIND   = 1'b1;

    // Response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_STORED  = 2'd0,
        ST_FULL    = 2'd1,
        ST_FOUND   = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_DONE
    } t_state;

    // One table entry as stored in memory
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_entry;

    // Controller to probe generator
    typedef struct packed {
        logic start;
        logic halt;
    } t_probe_ctl;

    // Probe generator to controller
    typedef struct packed {
        logic issue;
        logic exhausted;
    } t_probe_sts;

endpackage

@@ rtl/dht_req_if.sv @@
`timescale 1ns / 1ps

interface dht_req_if;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [dht_pkg::KEY_W-1:0]  probe_key;
    logic [dht_pkg::TAG_W-1:0]  name_tag;

    modport source (output valid, action, probe_key, name_tag, input ready);
    modport sink   (input valid, action, probe_key, name_tag, output ready);
endinterface

@@ rtl/dht_rsp_if.sv @@
`timescale 1ns / 1ps

interface dht_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [dht_pkg::STATUS_W-1:0]  status;
    logic [dht_pkg::SLOT_W-1:0]    slot;

    modport source (output valid, status, slot, input ready);
    modport sink   (input valid, status, slot, output ready);
endinterface

@@ rtl/dht_mem.sv @@
`timescale 1ns / 1ps

module dht_mem #(
    parameter int DEPTH = dht_pkg::TABLE_SIZE_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  dht_pkg::t_entry  i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output dht_pkg::t_entry  o_rdata
);

    dht_pkg::t_entry r_mem [DEPTH];
    dht_pkg::t_entry r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/dht_hash.sv @@
`timescale 1ns / 1ps

module dht_hash #(
    parameter int TABLE_SIZE = dht_pkg::TABLE_SIZE_DEF,
    parameter int W          = $clog2(TABLE_SIZE)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [dht_pkg::KEY_W-1:0]  i_key,
    output logic                       o_done,
    output logic [W-1:0]               o_pos,
    output logic [W-1:0]               o_stride
);

    // floor(k / d) equals (k * ceil(2^s / d)) >> s for every key k when
    // s = KEY_W + ceil(log2 d); the reciprocal fits in KEY_W+1 bits
    localparam int KW   = dht_pkg::KEY_W;
    localparam int PW   = 2 * KW + 1;
    localparam int SH_P = KW + $clog2(TABLE_SIZE);
    localparam int SH_S = KW + $clog2(TABLE_SIZE - 1);
    localparam logic [KW:0] RCP_P =
        (KW+1)'(((longint'(1) << SH_P) + longint'(TABLE_SIZE - 1)) / longint'(TABLE_SIZE));
    localparam logic [KW:0] RCP_S =
        (KW+1)'(((longint'(1) << SH_S) + longint'(TABLE_SIZE - 2))
                / longint'(TABLE_SIZE - 1));
    localparam logic [KW-1:0] MOD_P = KW'(TABLE_SIZE);
    localparam logic [KW-1:0] MOD_S = KW'(TABLE_SIZE - 1);

    logic [KW-1:0] r_key;
    logic [KW-1:0] r_quo_p;
    logic [KW-1:0] r_quo_s;
    logic [W-1:0]  r_rem_p;
    logic [W-1:0]  r_rem_s;
    logic          r_ph1;
    logic          r_ph2;
    logic          r_done;
    logic [PW-1:0] prod_p;
    logic [PW-1:0] prod_s;
    logic [KW-1:0] n_quo_p;
    logic [KW-1:0] n_quo_s;
    logic [KW-1:0] diff_p;
    logic [KW-1:0] diff_s;

    // First step: quotients by reciprocal multiplication
    always_comb begin
        prod_p  = PW'(r_key) * PW'(RCP_P);
        prod_s  = PW'(r_key) * PW'(RCP_S);
        n_quo_p = KW'(prod_p >> SH_P);
        n_quo_s = KW'(prod_s >> SH_S);
    end

    // Second step: remainders as key minus quotient times modulus
    always_comb begin
        diff_p = r_key - r_quo_p * MOD_P;
        diff_s = r_key - r_quo_s * MOD_S;
    end

    // Sequence control: start, quotient step, remainder step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph1  <= 1'b0;
            r_ph2  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_ph1  <= i_start;
            r_ph2  <= r_ph1;
            r_done <= r_ph2;
        end
    end

    // Remainder datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= i_key;
        end
        if (r_ph1) begin
            r_quo_p <= n_quo_p;
            r_quo_s <= n_quo_s;
        end
        if (r_ph2) begin
            r_rem_p <= diff_p[W-1:0];
            r_rem_s <= diff_s[W-1:0];
        end
    end

    assign o_done   = r_done;
    assign o_pos    = r_rem_p;
    assign o_stride = r_rem_s + 1'b1;

endmodule

@@ rtl/dht_probe.sv @@
`timescale 1ns / 1ps

module dht_probe #(
    parameter int TABLE_SIZE = dht_pkg::TABLE_SIZE_DEF,
    parameter int W          = $clog2(TABLE_SIZE)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dht_pkg::t_probe_ctl  i_ctl,
    input  logic [W-1:0]         i_pos,
    input  logic [W-1:0]         i_stride,
    output dht_pkg::t_probe_sts  o_sts,
    output logic [W-1:0]         o_addr
);

    localparam int NW = $clog2(TABLE_SIZE + 1);
    localparam logic [NW-1:0] N_ALL = NW'(TABLE_SIZE);
    localparam logic [W:0]    MOD   = (W+1)'(TABLE_SIZE);

    logic [W-1:0]  r_pos;
    logic [W-1:0]  r_stride;
    logic [NW-1:0] r_issued;
    logic          r_active;
    logic          issue;
    logic [W:0]    sum;
    logic [W-1:0]  n_pos;

    // Issue one read per cycle while active, until all positions are covered or the controller halts
    assign issue = r_active && !i_ctl.halt && (r_issued != N_ALL);

    // Next position on the probe sequence, wrapped once
    always_comb begin
        sum = {1'b0, r_pos} + {1'b0, r_stride};
        if (sum >= MOD) begin
            sum = sum - MOD;
        end
        n_pos = sum[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_issued <= '0;
        end else if (i_ctl.start) begin
            r_active <= 1'b1;
            r_issued <= '0;
        end else if (i_ctl.halt) begin
            r_active <= 1'b0;
        end else if (issue) begin
            r_issued <= r_issued + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_pos    <= i_pos;
            r_stride <= i_stride;
        end else if (issue) begin
            r_pos <= n_pos;
        end
    end

    assign o_addr          = r_pos;
    assign o_sts.issue     = issue;
    assign o_sts.exhausted = (r_issued == N_ALL);

endmodule

@@ rtl/double_hash_table.sv @@
`timescale 1ns / 1ps
// Open-addressing hash table with double hashing over TABLE_SIZE (prime) slots.
// Requests arrive on i_req (action, probe_key, name_tag); one response per
// request leaves on o_rsp (status, slot), both valid/ready channels.
// Insert writes the first empty slot on the key's probe sequence (stored, or
// table full with slot 0). Find walks the sequence up to the first valid slot
// with an equal tag (found, or not found with slot 0 after the whole sequence).
// From the request transfer to o_rsp.valid, the key is reduced modulo
// TABLE_SIZE and TABLE_SIZE-1 by reciprocal multiplication, the probe sequence
// is loaded, one read is made per probed slot, the last read is checked and
// the output register is loaded.
// One request is worked on at a time; the next one is taken the cycle after the
// current result enters the output register.
// Reset starts a clearing pass that writes every slot empty, one per cycle,
// during which i_req.ready stays low.
// The response sits in an output register: a stalled receiver holds it there
// while the next request is still taken and processed; that request's result
// then waits until the register frees up.
`include "assert_macros.svh"

module double_hash_table #(
    parameter int TABLE_SIZE = dht_pkg::TABLE_SIZE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dht_req_if.sink    i_req,
    dht_rsp_if.source  o_rsp
);

    localparam int W = $clog2(TABLE_SIZE);
    localparam logic [W-1:0] LAST = W'(TABLE_SIZE - 1);

    dht_pkg::t_state   r_state;
    dht_pkg::t_state   n_state;
    logic [W-1:0]      r_clr_addr;
    logic              r_action;
    logic [dht_pkg::KEY_W-1:0] r_key;
    logic [dht_pkg::TAG_W-1:0] r_tag;
    logic              r_chk_valid;
    logic [W-1:0]      r_chk_pos;
    dht_pkg::t_status  r_res_status;
    logic [dht_pkg::SLOT_W-1:0] r_res_slot;
    logic              r_out_valid;
    dht_pkg::t_status  r_out_status;
    logic [dht_pkg::SLOT_W-1:0] r_out_slot;

    logic              accept;
    logic              hash_done;
    logic [W-1:0]      hash_pos;
    logic [W-1:0]      hash_stride;
    dht_pkg::t_probe_ctl probe_ctl;
    dht_pkg::t_probe_sts probe_sts;
    logic [W-1:0]      rd_addr;
    dht_pkg::t_entry   rd_data;
    logic              mem_we;
    logic [W-1:0]      mem_waddr;
    dht_pkg::t_entry   mem_wdata;
    logic              hit;
    logic              chk_hit;
    logic              chk_miss;
    logic              out_free;
    logic              in_clear;
    logic              in_probe;
    logic              is_insert;

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;

    // Key hashing
    dht_hash #(.TABLE_SIZE(TABLE_SIZE), .W(W)) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_key    (i_req.probe_key),
        .o_done   (hash_done),
        .o_pos    (hash_pos),
        .o_stride (hash_stride)
    );

    // Probe address sequence
    dht_probe #(.TABLE_SIZE(TABLE_SIZE), .W(W)) u_probe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (probe_ctl),
        .i_pos    (hash_pos),
        .i_stride (hash_stride),
        .o_sts    (probe_sts),
        .o_addr   (rd_addr)
    );

    // Entry memory
    dht_mem #(.DEPTH(TABLE_SIZE), .AW(W)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (probe_sts.issue),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Evaluate the entry read in the previous cycle
    always_comb begin
        if (r_action == dht_pkg::ACT_FIND) begin
            hit = rd_data.valid && (rd_data.tag == r_tag);
        end else begin
            hit = !rd_data.valid;
        end
        chk_hit  = (r_state == dht_pkg::S_PROBE) && r_chk_valid && hit;
        chk_miss = (r_state == dht_pkg::S_PROBE) && r_chk_valid && !hit
                   && probe_sts.exhausted;
    end

    assign probe_ctl.start = hash_done;
    assign probe_ctl.halt  = chk_hit;

    // Memory write: clearing pass or insert commit
    always_comb begin
        mem_wdata.key = r_key;
        mem_wdata.tag = r_tag;
        if (r_state == dht_pkg::S_CLEAR) begin
            mem_we          = 1'b1;
            mem_waddr       = r_clr_addr;
            mem_wdata.valid = 1'b0;
        end else begin
            mem_we          = chk_hit && (r_action == dht_pkg::ACT_INSERT);
            mem_waddr       = r_chk_pos;
            mem_wdata.valid = 1'b1;
        end
    end

    // Next state
    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        case (r_state)
            dht_pkg::S_CLEAR: begin
                if (r_clr_addr == LAST) begin
                    n_state = dht_pkg::S_IDLE;
                end
            end
            dht_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_state = dht_pkg::S_HASH;
                end
            end
            dht_pkg::S_HASH: begin
                if (hash_done) begin
                    n_state = dht_pkg::S_PROBE;
                end
            end
            dht_pkg::S_PROBE: begin
                if (chk_hit || chk_miss) begin
                    n_state = dht_pkg::S_DONE;
                end
            end
            dht_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = dht_pkg::S_IDLE;
                end
            end
            default: n_state = dht_pkg::S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dht_pkg::S_CLEAR;
            r_clr_addr  <= '0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chk_valid <= (r_state == dht_pkg::S_PROBE) && probe_sts.issue
                           && !chk_hit && !chk_miss;
            if (r_state == dht_pkg::S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == dht_pkg::S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture, probe tracking and results
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_req.action;
            r_key    <= i_req.probe_key;
            r_tag    <= i_req.name_tag;
        end
        r_chk_pos <= rd_addr;
        if (chk_hit) begin
            r_res_status <= (r_action == dht_pkg::ACT_FIND) ? dht_pkg::ST_FOUND
                                                            : dht_pkg::ST_STORED;
            r_res_slot   <= dht_pkg::SLOT_W'(r_chk_pos);
        end else if (chk_miss) begin
            r_res_status <= (r_action == dht_pkg::ACT_FIND) ? dht_pkg::ST_MISSING
                                                            : dht_pkg::ST_FULL;
            r_res_slot   <= '0;
        end
        if (r_state == dht_pkg::S_DONE && out_free) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
        end
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_out_status;
    assign o_rsp.slot   = r_out_slot;

    // Shorthands for the checks below
    assign in_clear  = (r_state == dht_pkg::S_CLEAR);
    assign in_probe  = (r_state == dht_pkg::S_PROBE);
    assign is_insert = (r_action == dht_pkg::ACT_INSERT);

    // Memory writes only come from the clearing pass or an insert commit
    `ASSERT_IMPLY(a_wr_src, i_clk, i_rst_n, mem_we, in_clear || (in_probe && is_insert))
    // Probe reads stay inside the table
    `ASSERT_IMPLY(a_rd_range, i_clk, i_rst_n, probe_sts.issue, rd_addr <= LAST)
    // A checked entry always comes from a read issued in the previous cycle
    `ASSERT_IMPLY(a_chk_src, i_clk, i_rst_n, r_chk_valid, $past(probe_sts.issue))
    // An insert never takes a slot that already holds a valid entry
    `ASSERT_NEVER(a_find_only, i_clk, i_rst_n, chk_hit && is_insert && rd_data.valid)

endmodule
